>>> rtl/core/ccfr_pkg.sv
// package for the cobs deframer with crc-32 check
// types, codes, constants and the byte-wise crc function
// no dependencies
package ccfr_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int MAX_ENCODED  = 4096;

    localparam int CFG_W   = 13;
    localparam int COUNT_W = 13;
    localparam int INDEX_W = 12;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 32;
    localparam int DELAY_DEPTH = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
    localparam logic [CRC_W-1:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [BYTE_W-1:0] FULL_CODE = 8'hFF;

    // largest limit the 13-bit register can express is 8191
    localparam int LIMIT_CAP_INT = (MAX_ENCODED > 8191) ? 8191 : MAX_ENCODED;
    localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(LIMIT_CAP_INT);
    localparam logic [COUNT_W-1:0] MIN_DECODED = COUNT_W'(HEADER_BYTES + DELAY_DEPTH);

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_OVERSIZED    = 3'd1,
        ST_BAD_COBS     = 3'd2,
        ST_SHORT        = 3'd3,
        ST_CRC_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic                frame_end;
        logic [BYTE_W-1:0]   out_byte;
        logic [INDEX_W-1:0]  byte_index;
        status_t             status;
        logic [INDEX_W-1:0]  payload_length;
    } result_t;

    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/ccfr_if.sv
// channel interfaces for the cobs deframer: byte input and result output
// depends on ccfr_pkg
interface ccfr_in_if;
    import ccfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfr_out_if;
    import ccfr_pkg::*;
    logic               valid;
    logic               ready;
    logic               frame_end;
    logic [BYTE_W-1:0]  out_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [2:0]         status;
    logic [INDEX_W-1:0] payload_length;

    modport source (output valid, output frame_end, output out_byte, output byte_index,
                    output status, output payload_length, input ready);
    modport sink   (input valid, input frame_end, input out_byte, input byte_index,
                    input status, input payload_length, output ready);
endinterface

>>> rtl/core/ccfr_in_reg.sv
// input register: holds one received byte until the decoder takes it
// depends on ccfr_pkg and ccfr_in_if
module ccfr_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    ccfr_in_if.sink                    rx,
    input  logic                       advance,
    output logic                       item_valid,
    output logic [ccfr_pkg::BYTE_W-1:0] item_byte
);
    import ccfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
endmodule

>>> rtl/core/ccfr_decode.sv
// frame state, cobs group decoding, trailer delay line and crc-32
// depends on ccfr_pkg
module ccfr_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ccfr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        advance,
    input  logic [ccfr_pkg::BYTE_W-1:0] item_byte,
    output logic                        res_valid,
    output ccfr_pkg::result_t           res
);
    import ccfr_pkg::*;

    logic [CFG_W-1:0]   max_len_reg;
    logic [BYTE_W-1:0]  group_left_reg, group_left_next;
    logic               group_full_reg, group_full_next;
    logic [BYTE_W-1:0]  delay_reg [DELAY_DEPTH];
    logic [BYTE_W-1:0]  delay_next [DELAY_DEPTH];
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [COUNT_W-1:0] dec_count_reg, dec_count_next;
    logic [COUNT_W-1:0] enc_count_reg, enc_count_next;
    logic               oversize_reg, oversize_next;

    logic [CFG_W-1:0]   limit;
    logic               push;
    logic [BYTE_W-1:0]  push_byte;
    logic               clear;
    logic [CRC_W-1:0]   trailer;
    logic [COUNT_W-1:0] idx_full;
    logic [COUNT_W-1:0] plen_full;

    assign limit     = (max_len_reg < LIMIT_CAP) ? max_len_reg : LIMIT_CAP;
    assign trailer   = {delay_reg[3], delay_reg[2], delay_reg[1], delay_reg[0]};
    assign idx_full  = dec_count_reg - COUNT_W'(DELAY_DEPTH);
    assign plen_full = dec_count_reg - MIN_DECODED;

    always_comb
    begin
        group_left_next = group_left_reg;
        group_full_next = group_full_reg;
        crc_next        = crc_reg;
        dec_count_next  = dec_count_reg;
        enc_count_next  = enc_count_reg;
        oversize_next   = oversize_reg;
        for (int i = 0; i < DELAY_DEPTH; i++)
        begin
            delay_next[i] = delay_reg[i];
        end
        push      = 1'b0;
        push_byte = '0;
        clear     = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        if (item_byte == '0)
        begin
            if (enc_count_reg != '0 || oversize_reg)
            begin
                clear         = 1'b1;
                res_valid     = 1'b1;
                res.frame_end = 1'b1;
                if (oversize_reg)
                begin
                    res.status = ST_OVERSIZED;
                end
                else if (group_left_reg != '0)
                begin
                    res.status = ST_BAD_COBS;
                end
                else if (dec_count_reg < MIN_DECODED)
                begin
                    res.status = ST_SHORT;
                end
                else if ((crc_reg ^ CRC_INIT) != trailer)
                begin
                    res.status = ST_CRC_MISMATCH;
                end
                else
                begin
                    res.status         = ST_OK;
                    res.payload_length = plen_full[INDEX_W-1:0];
                end
            end
        end
        else if (!oversize_reg)
        begin
            enc_count_next = enc_count_reg + COUNT_W'(1);
            if (({1'b0, enc_count_reg} + (COUNT_W+1)'(2)) > {1'b0, limit})
            begin
                oversize_next = 1'b1;
            end
            else if (group_left_reg == '0)
            begin
                push            = !group_full_reg;
                push_byte       = '0;
                group_full_next = (item_byte == FULL_CODE);
                group_left_next = item_byte - BYTE_W'(1);
            end
            else
            begin
                group_left_next = group_left_reg - BYTE_W'(1);
                push            = 1'b1;
                push_byte       = item_byte;
            end
        end

        if (push)
        begin
            if (dec_count_reg >= COUNT_W'(DELAY_DEPTH))
            begin
                crc_next       = crc32_byte(crc_reg, delay_reg[0]);
                res_valid      = 1'b1;
                res.out_byte   = delay_reg[0];
                res.byte_index = idx_full[INDEX_W-1:0];
            end
            for (int i = 0; i < DELAY_DEPTH - 1; i++)
            begin
                delay_next[i] = delay_reg[i+1];
            end
            delay_next[DELAY_DEPTH-1] = push_byte;
            dec_count_next = dec_count_reg + COUNT_W'(1);
        end

        if (clear)
        begin
            group_left_next = '0;
            group_full_next = 1'b1;
            crc_next        = CRC_INIT;
            dec_count_next  = '0;
            enc_count_next  = '0;
            oversize_next   = 1'b0;
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                delay_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_left_reg <= '0;
            group_full_reg <= 1'b1;
            crc_reg        <= CRC_INIT;
            dec_count_reg  <= '0;
            enc_count_reg  <= '0;
            oversize_reg   <= 1'b0;
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            group_left_reg <= group_left_next;
            group_full_reg <= group_full_next;
            crc_reg        <= crc_next;
            dec_count_reg  <= dec_count_next;
            enc_count_reg  <= enc_count_next;
            oversize_reg   <= oversize_next;
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                delay_reg[i] <= delay_next[i];
            end
        end
    end
endmodule

>>> rtl/core/ccfr_out_reg.sv
// result register driving the output channel
// depends on ccfr_pkg and ccfr_out_if
module ccfr_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              res_valid,
    input  ccfr_pkg::result_t res,
    output logic              can_load,
    ccfr_out_if.source        result
);
    import ccfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    logic    load;

    assign can_load   = !valid_reg || result.ready;
    assign load       = advance && res_valid;
    assign valid_next = load ? 1'b1 : ((valid_reg && result.ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.frame_end      = data_reg.frame_end;
    assign result.out_byte       = data_reg.out_byte;
    assign result.byte_index     = data_reg.byte_index;
    assign result.status         = data_reg.status;
    assign result.payload_length = data_reg.payload_length;
endmodule

>>> rtl/core/cobs_crc32_frame_receiver.sv
// top level of the cobs deframer with crc-32 check
// depends on ccfr_pkg, ccfr_if, ccfr_in_reg, ccfr_decode, ccfr_out_reg
//
//   channel   dir   handshake      payload
//   rx        in    valid/ready    rx_byte
//   result    out   valid/ready    frame_end, out_byte, byte_index, status, payload_length
//   cfg       in    cfg_wr_en      cfg_wr_data (max_encoded_len)
//
// one byte per cycle unless the result stalls; each byte passes the input register, then
// the cobs, crc and status logic into the result register
// every byte gives at most one transfer; a body byte appears four decoded bytes late
// reset clears the frame state and sets max_encoded_len to 4096
// a stalled result holds the decoder and the input register, rx.ready drops
module cobs_crc32_frame_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    ccfr_in_if.sink                     rx,
    ccfr_out_if.source                  result,
    input  logic                        cfg_wr_en,
    input  logic [ccfr_pkg::CFG_W-1:0]  cfg_wr_data
);
    import ccfr_pkg::*;

    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              can_load;
    logic              advance;
    logic              res_valid;
    result_t           res;

    assign advance = item_valid && can_load;

    ccfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    ccfr_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item_byte   (item_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    ccfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .result    (result)
    );
endmodule

>>> rtl/core/ccfr_checker.sv
// port-level checks for the cobs deframer and the bind that attaches them
// depends on ccfr_pkg and cobs_crc32_frame_receiver
module ccfr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_frame_end,
    input logic [ccfr_pkg::BYTE_W-1:0]  res_out_byte,
    input logic [ccfr_pkg::INDEX_W-1:0] res_byte_index,
    input logic [2:0]                   res_status,
    input logic [ccfr_pkg::INDEX_W-1:0] res_payload_length
);
    import ccfr_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_frame_end)
            && $stable(res_out_byte) && $stable(res_byte_index)
            && $stable(res_status) && $stable(res_payload_length))
        else $error("result changed while stalled");

    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_frame_end |-> res_out_byte == '0 && res_byte_index == '0
            && res_status <= 3'(ST_CRC_MISMATCH))
        else $error("bad status transfer");

    a_body_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_frame_end |-> res_status == 3'(ST_OK) && res_payload_length == '0)
        else $error("bad body byte transfer");

    a_plen_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != 3'(ST_OK) |-> res_payload_length == '0)
        else $error("payload length with failed status");
endmodule

bind cobs_crc32_frame_receiver ccfr_checker u_ccfr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .res_frame_end      (result.frame_end),
    .res_out_byte       (result.out_byte),
    .res_byte_index     (result.byte_index),
    .res_status         (result.status),
    .res_payload_length (result.payload_length)
);
